### src/remote_debug_packet_deframer_core_assert.svh
// Assertion macros shared by the deframer checker.
`ifndef REMOTE_DEBUG_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define REMOTE_DEBUG_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define RDPD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define RDPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rdpd_pkg.sv
// Package with codes, queue entry type and hex decode for the packet deframer.
`timescale 1ns / 1ps
package rdpd_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_NAK   = 2'd3;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_VERDICT = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [7:0] check;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.val = 4'(c[3:0] + 4'd9);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### src/rdpd_front.sv
// Front part: framing state machine, running sum and checksum digit parse.
`timescale 1ns / 1ps
module rdpd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     rx_byte,
  input  logic           full,
  output logic           push,
  output rdpd_pkg::entry_t entry
);
  import rdpd_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_DIG1 = 2'd2;
  localparam logic [1:0] PH_DIG2 = 2'd3;

  logic [1:0] phase, phase_next;
  logic [7:0] sum, sum_next;
  logic [3:0] dig_val, dig_val_next;
  logic       dig_ok, dig_ok_next;
  logic       accept;
  logic       emit;
  hex_t       hex;
  logic [7:0] parsed;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push     = accept && emit;
  assign hex      = hex_decode(rx_byte);

  always_comb begin
    if (!dig_ok) begin
      parsed = 8'd0;
    end else if (hex.ok) begin
      parsed = {dig_val, hex.val};
    end else begin
      parsed = {4'd0, dig_val};
    end
  end

  always_comb begin
    phase_next   = phase;
    sum_next     = sum;
    dig_val_next = dig_val;
    dig_ok_next  = dig_ok;
    emit         = 1'b0;
    entry.op     = OP_START;
    entry.data   = 8'd0;
    entry.check  = 8'd0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_START) begin
          sum_next   = 8'd0;
          phase_next = PH_BODY;
          emit       = 1'b1;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_END) begin
          phase_next = PH_DIG1;
        end else begin
          sum_next   = sum + rx_byte;
          emit       = 1'b1;
          entry.op   = OP_DATA;
          entry.data = rx_byte;
        end
      end
      PH_DIG1: begin
        dig_val_next = hex.val;
        dig_ok_next  = hex.ok;
        phase_next   = PH_DIG2;
      end
      default: begin
        phase_next  = PH_HUNT;
        emit        = 1'b1;
        entry.op    = OP_VERDICT;
        entry.data  = sum;
        entry.check = parsed;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      sum     <= 8'd0;
      dig_val <= 4'd0;
      dig_ok  <= 1'b0;
    end else if (accept) begin
      phase   <= phase_next;
      sum     <= sum_next;
      dig_val <= dig_val_next;
      dig_ok  <= dig_ok_next;
    end
  end

endmodule

### src/rdpd_queue.sv
// Short queue of classified entries between the front and back parts.
`timescale 1ns / 1ps
module rdpd_queue #(
  parameter int DEPTH = rdpd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rdpd_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output rdpd_pkg::entry_t rd_entry
);
  import rdpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/rdpd_back.sv
// Back part: checksum verdict and output register.
`timescale 1ns / 1ps
module rdpd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  rdpd_pkg::entry_t q_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data,
  output logic             last
);
  import rdpd_pkg::*;

  logic [1:0] kind_next;
  logic       load;

  assign load = !out_valid || !out_stall;
  assign pop  = q_valid && load;

  always_comb begin
    case (q_entry.op)
      OP_START:   kind_next = KIND_START;
      OP_DATA:    kind_next = KIND_DATA;
      OP_VERDICT: kind_next = (q_entry.check == q_entry.data) ? KIND_ACK : KIND_NAK;
      default:    kind_next = KIND_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= kind_next;
      data <= q_entry.data;
      last <= (q_entry.op == OP_VERDICT);
    end
  end

endmodule

### src/remote_debug_packet_deframer_core.sv
// A result is written into the queue when its byte is accepted, then moves into the output register.
// Throughput: one byte per cycle; the two-entry queue and the output register set it,
// and the input stalls only when the queue is full.
// Bytes that start no result ('#', first checksum digit, bytes while hunting) push nothing into the queue.
// Reset is synchronous, active high: hunting phase, zero sum, empty queue, no output.
`timescale 1ns / 1ps
module remote_debug_packet_deframer_core #(
  parameter int QUEUE_DEPTH = rdpd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic       last
);
  import rdpd_pkg::*;

  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t wr_entry;
  entry_t rd_entry;

  rdpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .full     (full),
    .push     (push),
    .entry    (wr_entry)
  );

  rdpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .rd_entry (rd_entry)
  );

  rdpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (rd_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data      (data),
    .last      (last)
  );

endmodule

### src/rdpd_checker.sv
// Port-level checker for the packet deframer and its bind.
`timescale 1ns / 1ps
`include "remote_debug_packet_deframer_core_assert.svh"
module rdpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] data,
  input logic       last
);
  import rdpd_pkg::*;

  `RDPD_ASSERT(a_in_hold, clk, rst, in_valid && in_stall |=> in_valid && $stable(rx_byte), "stalled input transaction changed")
  `RDPD_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data) && $stable(last), "stalled output transaction changed")
  `RDPD_ASSERT(a_last_verdict, clk, rst, out_valid |-> (last == (kind == KIND_ACK || kind == KIND_NAK)), "last does not mark a verdict")
  `RDPD_ASSERT(a_start_zero, clk, rst, out_valid && kind == KIND_START |-> data == 8'd0, "start transaction carries data")
  `RDPD_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind remote_debug_packet_deframer_core rdpd_checker u_rdpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .rx_byte   (rx_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .data      (data),
  .last      (last)
);

### sim/remote_debug_packet_deframer_core_tb.sv
// Self-checking testbench for the debug packet deframer with a byte-level predictor.
`timescale 1ns / 1ps
module remote_debug_packet_deframer_core_tb;
  import rdpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_DIGIT_HI,
    PH_DIGIT_LO
  } deframe_phase_e;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } frame_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;

  logic [7:0]     rx_stream[$];
  frame_event_t   pending_events[$];
  frame_event_t   next_event;
  deframe_phase_e phase = PH_HUNT;
  logic [7:0]     payload_sum = 8'h00;
  logic [3:0]     hi_val = 4'h0;
  logic           hi_ok = 1'b0;
  int             send_gap = 0;
  int             stall_left = 0;
  int             in_calm = 0;
  int             out_calm = 0;
  int             bytes_taken = 0;
  int             stream_len = 0;
  int             mismatch_count = 0;

  remote_debug_packet_deframer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .data     (data),
    .last     (last)
  );

  always #2 clk = ~clk;

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    return 5'b0_0000;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + nib;
    return 8'((upper ? 8'h41 : 8'h61) + nib - 4'd10);
  endfunction

  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_stream = {rx_stream, b};
  endtask

  task automatic queue_event(input frame_event_t ev);
    pending_events = {pending_events, ev};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic deframe_byte(input logic [7:0] c);
    frame_event_t ev;
    logic [4:0]   lo;
    logic [7:0]   parsed;
    ev.kind = KIND_START;
    ev.data = 8'h00;
    ev.last = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (c == CH_START) begin
          payload_sum = 8'h00;
          phase = PH_BODY;
          queue_event(ev);
        end
      end
      PH_BODY: begin
        if (c == CH_END) begin
          phase = PH_DIGIT_HI;
        end else begin
          payload_sum = payload_sum + c;
          ev.kind = KIND_DATA;
          ev.data = c;
          queue_event(ev);
        end
      end
      PH_DIGIT_HI: begin
        {hi_ok, hi_val} = hex_nibble(c);
        phase = PH_DIGIT_LO;
      end
      default: begin
        lo = hex_nibble(c);
        if (!hi_ok) parsed = 8'h00;
        else if (lo[4]) parsed = {hi_val, lo[3:0]};
        else parsed = {4'h0, hi_val};
        ev.kind = (parsed == payload_sum) ? KIND_ACK : KIND_NAK;
        ev.data = payload_sum;
        ev.last = 1'b1;
        queue_event(ev);
        phase = PH_HUNT;
      end
    endcase
  endtask

  // Driver: hold each byte until accepted, then advance after a random gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        deframe_byte(rx_byte);
        bytes_taken++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (rx_stream.size() > 0) begin
        rx_byte  <= rx_stream.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_idle(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each transaction with the oldest predicted event.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind=%0d data=%02h last=%0b",
                                  kind, data, last));
        end else begin
          next_event = pending_events.pop_front();
          if (kind !== next_event.kind)
            flag_mismatch($sformatf("kind %0d, predicted %0d", kind, next_event.kind));
          if (data !== next_event.data)
            flag_mismatch($sformatf("data %02h, predicted %02h", data, next_event.data));
          if (last !== next_event.last)
            flag_mismatch($sformatf("last %0b, predicted %0b", last, next_event.last));
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= pick_idle(out_calm);
      end
    end
  end

  initial begin
    int         len;
    int         r;
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] chk;

    queue_byte(8'h00);
    queue_byte(8'hFF);
    push_text("#");
    push_text("$#00");
    push_text("$");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    push_text("#ff");
    push_text("$$#2A");
    push_text("$");
    queue_byte(8'h05);
    push_text("#5g");
    push_text("$A#z1");

    while (rx_stream.size() < 645) begin
      repeat ($urandom_range(0, 2)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_START);
        queue_byte(b);
      end
      len = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 48) : $urandom_range(0, 8);
      sum = 8'h00;
      queue_byte(CH_START);
      for (int i = 0; i < len; i++) begin
        do begin
          if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
          else b = 8'($urandom_range(8'h20, 8'h7E));
        end while (b == CH_END);
        sum = sum + b;
        queue_byte(b);
      end
      queue_byte(CH_END);
      r = $urandom_range(0, 99);
      chk = (r < 70) ? sum : 8'($urandom_range(0, 255));
      if (r < 88) begin
        queue_byte(hex_char(chk[7:4], 1'($urandom_range(0, 1))));
        queue_byte(hex_char(chk[3:0], 1'($urandom_range(0, 1))));
      end else begin
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte(8'($urandom_range(0, 255)));
      end
    end
    stream_len = rx_stream.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < stream_len) @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
